// ----- design/graph_bfs_dfs_traversal_defines.svh -----
// ----------------------------------------------------------------------------
// graph traversal assertion macros
// shared property forms for the traversal block
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH

// same-cycle implication
`define GBT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbt assertion failed");

// next-cycle implication
`define GBT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbt assertion failed");

`endif

// ----- design/gbt_pkg.sv -----
// ----------------------------------------------------------------------------
// gbt_pkg
// types and codes shared by the graph traversal block
// ----------------------------------------------------------------------------
package gbt_pkg;

   localparam int NODE_W   = 6;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_EDGE  = 2'd0,
      KIND_BFS   = 2'd1,
      KIND_DFS   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_VISIT   = 2'd0,
      ST_STORED  = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APP_RD,
      S_APP_WR,
      S_EDGE_DONE,
      S_CLEAR_DONE,
      S_BFS_POP,
      S_BFS_VTX,
      S_BFS_HEAD,
      S_BFS_ARC,
      S_BFS_ADJ,
      S_DFS_START,
      S_DFS_HEAD,
      S_DFS_ARC,
      S_DFS_POP,
      S_DFS_ADJ,
      S_FINISH
   } state_type;

endpackage

// ----- design/gbt_if.sv -----
// ----------------------------------------------------------------------------
// gbt channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface gbt_req_if;
   logic                          valid;
   logic                          ready;
   logic [gbt_pkg::KIND_W-1:0]    kind;
   logic [gbt_pkg::NODE_W-1:0]    first_node;
   logic [gbt_pkg::NODE_W-1:0]    second_node;
   logic                          directed;

   modport source (output valid, kind, first_node, second_node, directed, input ready);
   modport sink   (input valid, kind, first_node, second_node, directed, output ready);
endinterface

interface gbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gbt_pkg::NODE_W-1:0]    node;
   logic [gbt_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport source (output valid, node, status, last, input ready);
   modport sink   (input valid, node, status, last, output ready);
endinterface

// ----- design/graph_bfs_dfs_traversal.sv -----
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// adjacency-list graph store with breadth-first and depth-first traversal
// ----------------------------------------------------------------------------
// Holds a graph of up to NODES vertices whose adjacency lists live in a pool
// of ARCS arcs. One request item at a time is taken: add edge, bfs, dfs or
// clear. Add edge does, per arc, a read of the list head/tail memory, then
// the write back, and then the reply; a dropped edge goes straight to the
// reply. Clear resets the list valid bits and the pool count, then replies.
// A bfs walk pops a vertex from the queue, emits it, reads its list head and
// scans its arcs; a dfs walk emits and pushes each new vertex, reads its list
// head, scans its arcs and pops a stack frame when the list ends. Each arc
// scanned waits for a registered read of the arc pool memory. Results leave
// through an output register, so a stalled consumer only freezes the walk.
// Vertices are emitted one behind the walk so the final one can carry last.
// There is no clearing pass after reset: list heads and visited marks are
// flip-flop valid bits.
`include "graph_bfs_dfs_traversal_defines.svh"

module graph_bfs_dfs_traversal #(
   parameter int NODES = 64,
   parameter int ARCS  = 256
) (
   input  logic      clock,
   input  logic      reset,
   gbt_req_if.sink   req,
   gbt_rsp_if.source rsp
);

   localparam int NODE_W = gbt_pkg::NODE_W;
   localparam int NW     = $clog2(NODES);      // vertex index bits
   localparam int SW     = $clog2(NODES + 1);  // queue / stack count bits
   localparam int AW     = $clog2(ARCS + 1);   // arc pointer incl. empty marker
   localparam int PW     = $clog2(ARCS);       // arc pool address bits
   localparam logic [AW-1:0]   EMPTY   = AW'(ARCS);
   localparam logic [NODE_W:0] NODES_X = (NODE_W+1)'(NODES);

   // memories
   logic [2*AW-1:0]   ht_mem  [NODES];   // {head, tail} per vertex
   logic [NODE_W-1:0] tgt_mem [ARCS];
   logic [AW-1:0]     nxt_mem [ARCS];
   logic [NODE_W-1:0] q_mem   [NODES];
   logic [AW-1:0]     st_mem  [NODES];

   logic [2*AW-1:0]   ht_q;
   logic [NODE_W-1:0] tgt_q;
   logic [AW-1:0]     nxt_q;
   logic [NODE_W-1:0] q_q;
   logic [AW-1:0]     st_q;

   // memory controls
   logic              ht_re, ht_we;
   logic [NW-1:0]     ht_raddr, ht_waddr;
   logic [2*AW-1:0]   ht_wdata;
   logic              arc_re, tgt_we, nxt_we;
   logic [PW-1:0]     arc_raddr, tgt_waddr, nxt_waddr;
   logic [NODE_W-1:0] tgt_wdata;
   logic [AW-1:0]     nxt_wdata;
   logic              q_re, q_we;
   logic [NW-1:0]     q_raddr, q_waddr;
   logic [NODE_W-1:0] q_wdata;
   logic              st_re, st_we;
   logic [NW-1:0]     st_raddr, st_waddr;
   logic [AW-1:0]     st_wdata;

   // control state
   gbt_pkg::state_type state_ff, state_in;
   logic [NODE_W-1:0]  from_ff, from_in, to_ff, to_in, x_ff, x_in;
   logic               second_ff, second_in, ok_ff, ok_in;
   logic [AW-1:0]      used_ff, used_in, p_ff, p_in;
   logic [NODES-1:0]   lvalid_ff, lvalid_in, visited_ff, visited_in;
   logic [SW-1:0]      rd_ff, rd_in, wr_ff, wr_in, sp_ff, sp_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [NODE_W-1:0]  hold_node_ff, hold_node_in;
   logic               out_valid_ff;
   logic [NODE_W-1:0]  out_node_ff;
   logic [gbt_pkg::STATUS_W-1:0] out_status_ff;
   logic               out_last_ff;

   logic               out_load;
   logic [NODE_W-1:0]  out_node_in;
   logic [gbt_pkg::STATUS_W-1:0] out_status_in;
   logic               out_last_in;

   logic               req_take, can_emit, go;
   logic [AW:0]        need_sum;
   logic [SW-1:0]      sp_m1, sp_m2;
   logic               t_ok;

   assign req.ready  = (state_ff == gbt_pkg::S_IDLE);
   assign req_take   = req.valid && req.ready;
   assign rsp.valid  = out_valid_ff;
   assign rsp.node   = out_node_ff;
   assign rsp.status = out_status_ff;
   assign rsp.last   = out_last_ff;

   assign can_emit = !out_valid_ff || rsp.ready;
   // a new vertex may be taken when the held one can move to the output
   assign go       = !hold_valid_ff || can_emit;
   assign sp_m1    = sp_ff - SW'(1);
   assign sp_m2    = sp_ff - SW'(2);
   assign need_sum = {1'b0, used_ff} + (req.directed ? (AW+1)'(1) : (AW+1)'(2));
   // neighbor in range and not yet seen
   assign t_ok     = ({1'b0, tgt_q} < NODES_X) && !visited_ff[tgt_q[NW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gbt_pkg::S_IDLE;
         used_ff       <= '0;
         lvalid_ff     <= '0;
         visited_ff    <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         lvalid_ff     <= lvalid_in;
         visited_ff    <= visited_in;
         hold_valid_ff <= hold_valid_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload and pointer registers
   always_ff @(posedge clock) begin
      from_ff      <= from_in;
      to_ff        <= to_in;
      x_ff         <= x_in;
      second_ff    <= second_in;
      ok_ff        <= ok_in;
      p_ff         <= p_in;
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      sp_ff        <= sp_in;
      hold_node_ff <= hold_node_in;
      if (out_load) begin
         out_node_ff   <= out_node_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      x_in          = x_ff;
      second_in     = second_ff;
      ok_in         = ok_ff;
      used_in       = used_ff;
      p_in          = p_ff;
      lvalid_in     = lvalid_ff;
      visited_in    = visited_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      sp_in         = sp_ff;
      hold_valid_in = hold_valid_ff;
      hold_node_in  = hold_node_ff;
      out_load      = 1'b0;
      out_node_in   = '0;
      out_status_in = gbt_pkg::ST_VISIT;
      out_last_in   = 1'b0;
      ht_re = 1'b0; ht_raddr = from_ff[NW-1:0];
      ht_we = 1'b0; ht_waddr = from_ff[NW-1:0]; ht_wdata = '0;
      arc_re = 1'b0; arc_raddr = p_ff[PW-1:0];
      tgt_we = 1'b0; tgt_waddr = used_ff[PW-1:0]; tgt_wdata = to_ff;
      nxt_we = 1'b0; nxt_waddr = used_ff[PW-1:0]; nxt_wdata = EMPTY;
      q_re = 1'b0; q_raddr = rd_ff[NW-1:0];
      q_we = 1'b0; q_waddr = wr_ff[NW-1:0]; q_wdata = tgt_q;
      st_re = 1'b0; st_raddr = sp_m2[NW-1:0];
      st_we = 1'b0; st_waddr = sp_m1[NW-1:0]; st_wdata = nxt_q;

      unique case (state_ff)
         gbt_pkg::S_IDLE: begin
            if (req_take) begin
               from_in   = req.first_node;
               to_in     = req.second_node;
               x_in      = req.first_node;
               second_in = !req.directed;
               unique case (req.kind)
                  gbt_pkg::KIND_EDGE: begin
                     ok_in = ({1'b0, req.first_node} < NODES_X) &&
                             ({1'b0, req.second_node} < NODES_X) &&
                             (need_sum <= {1'b0, EMPTY});
                     state_in = ok_in ? gbt_pkg::S_APP_RD : gbt_pkg::S_EDGE_DONE;
                  end
                  gbt_pkg::KIND_CLEAR: begin
                     lvalid_in = '0;
                     used_in   = '0;
                     state_in  = gbt_pkg::S_CLEAR_DONE;
                  end
                  default: begin
                     // traversal; a source out of range gives no result
                     if ({1'b0, req.first_node} < NODES_X) begin
                        visited_in = '0;
                        visited_in[req.first_node[NW-1:0]] = 1'b1;
                        if (req.kind == gbt_pkg::KIND_BFS) begin
                           q_we     = 1'b1;
                           q_waddr  = '0;
                           q_wdata  = req.first_node;
                           rd_in    = '0;
                           wr_in    = SW'(1);
                           state_in = gbt_pkg::S_BFS_POP;
                        end else begin
                           state_in = gbt_pkg::S_DFS_START;
                        end
                     end
                  end
               endcase
            end
         end

         // append one arc: new pool entry, then link from the list tail
         gbt_pkg::S_APP_RD: begin
            ht_re    = 1'b1;
            tgt_we   = 1'b1;
            nxt_we   = 1'b1;
            state_in = gbt_pkg::S_APP_WR;
         end
         gbt_pkg::S_APP_WR: begin
            ht_we = 1'b1;
            if (lvalid_ff[from_ff[NW-1:0]]) begin
               ht_wdata  = {ht_q[2*AW-1:AW], used_ff};
               nxt_we    = 1'b1;
               nxt_waddr = ht_q[PW-1:0];
               nxt_wdata = used_ff;
            end else begin
               ht_wdata = {used_ff, used_ff};
               lvalid_in[from_ff[NW-1:0]] = 1'b1;
            end
            used_in = used_ff + AW'(1);
            if (second_ff) begin
               from_in   = to_ff;
               to_in     = from_ff;
               second_in = 1'b0;
               state_in  = gbt_pkg::S_APP_RD;
            end else begin
               state_in = gbt_pkg::S_EDGE_DONE;
            end
         end
         gbt_pkg::S_EDGE_DONE: begin
            if (can_emit) begin
               out_load      = 1'b1;
               out_status_in = ok_ff ? gbt_pkg::ST_STORED : gbt_pkg::ST_FULL;
               out_last_in   = 1'b1;
               state_in      = gbt_pkg::S_IDLE;
            end
         end
         gbt_pkg::S_CLEAR_DONE: begin
            if (can_emit) begin
               out_load      = 1'b1;
               out_status_in = gbt_pkg::ST_CLEARED;
               out_last_in   = 1'b1;
               state_in      = gbt_pkg::S_IDLE;
            end
         end

         // breadth-first walk
         gbt_pkg::S_BFS_POP: begin
            if (rd_ff < wr_ff) begin
               q_re     = 1'b1;
               rd_in    = rd_ff + SW'(1);
               state_in = gbt_pkg::S_BFS_VTX;
            end else begin
               state_in = gbt_pkg::S_FINISH;
            end
         end
         gbt_pkg::S_BFS_VTX: begin
            if (go) begin
               if (hold_valid_ff) begin
                  out_load    = 1'b1;
                  out_node_in = hold_node_ff;
               end
               hold_valid_in = 1'b1;
               hold_node_in  = q_q;
               x_in          = q_q;
               ht_re         = 1'b1;
               ht_raddr      = q_q[NW-1:0];
               state_in      = gbt_pkg::S_BFS_HEAD;
            end
         end
         gbt_pkg::S_BFS_HEAD: begin
            p_in     = lvalid_ff[x_ff[NW-1:0]] ? ht_q[2*AW-1:AW] : EMPTY;
            state_in = gbt_pkg::S_BFS_ARC;
         end
         gbt_pkg::S_BFS_ARC: begin
            if (p_ff == EMPTY) begin
               state_in = gbt_pkg::S_BFS_POP;
            end else begin
               arc_re   = 1'b1;
               state_in = gbt_pkg::S_BFS_ADJ;
            end
         end
         gbt_pkg::S_BFS_ADJ: begin
            p_in = nxt_q;
            if (t_ok && (wr_ff < SW'(NODES))) begin
               visited_in[tgt_q[NW-1:0]] = 1'b1;
               q_we  = 1'b1;
               wr_in = wr_ff + SW'(1);
            end
            state_in = gbt_pkg::S_BFS_ARC;
         end

         // depth-first walk; top frame arc kept in p_ff, lower frames in memory
         gbt_pkg::S_DFS_START: begin
            if (go) begin
               if (hold_valid_ff) begin
                  out_load    = 1'b1;
                  out_node_in = hold_node_ff;
               end
               hold_valid_in = 1'b1;
               hold_node_in  = x_ff;
               ht_re         = 1'b1;
               ht_raddr      = x_ff[NW-1:0];
               sp_in         = '0;
               state_in      = gbt_pkg::S_DFS_HEAD;
            end
         end
         gbt_pkg::S_DFS_HEAD: begin
            p_in     = lvalid_ff[x_ff[NW-1:0]] ? ht_q[2*AW-1:AW] : EMPTY;
            sp_in    = sp_ff + SW'(1);
            state_in = gbt_pkg::S_DFS_ARC;
         end
         gbt_pkg::S_DFS_ARC: begin
            if (p_ff == EMPTY) begin
               sp_in = sp_m1;
               if (sp_ff == SW'(1)) begin
                  state_in = gbt_pkg::S_FINISH;
               end else begin
                  st_re    = 1'b1;
                  state_in = gbt_pkg::S_DFS_POP;
               end
            end else begin
               arc_re   = 1'b1;
               state_in = gbt_pkg::S_DFS_ADJ;
            end
         end
         gbt_pkg::S_DFS_POP: begin
            p_in     = st_q;
            state_in = gbt_pkg::S_DFS_ARC;
         end
         gbt_pkg::S_DFS_ADJ: begin
            if (t_ok && (sp_ff < SW'(NODES))) begin
               if (go) begin
                  if (hold_valid_ff) begin
                     out_load    = 1'b1;
                     out_node_in = hold_node_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_node_in  = tgt_q;
                  visited_in[tgt_q[NW-1:0]] = 1'b1;
                  st_we    = 1'b1;
                  x_in     = tgt_q;
                  ht_re    = 1'b1;
                  ht_raddr = tgt_q[NW-1:0];
                  state_in = gbt_pkg::S_DFS_HEAD;
               end
            end else begin
               p_in     = nxt_q;
               state_in = gbt_pkg::S_DFS_ARC;
            end
         end

         // release the held vertex as the final item
         gbt_pkg::S_FINISH: begin
            if (can_emit) begin
               out_load      = hold_valid_ff;
               out_node_in   = hold_node_ff;
               out_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = gbt_pkg::S_IDLE;
            end
         end
         default: state_in = gbt_pkg::S_IDLE;
      endcase
   end

   // memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (ht_we) ht_mem[ht_waddr] <= ht_wdata;
      if (ht_re) ht_q <= ht_mem[ht_raddr];
   end

   always_ff @(posedge clock) begin
      if (tgt_we) tgt_mem[tgt_waddr] <= tgt_wdata;
      if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
      if (arc_re) begin
         tgt_q <= tgt_mem[arc_raddr];
         nxt_q <= nxt_mem[arc_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      if (q_re) q_q <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_waddr] <= st_wdata;
      if (st_re) st_q <= st_mem[st_raddr];
   end

   // checks
   `GBT_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= EMPTY)
   `GBT_ASSERT_NXT(a_clear_used, clock, reset, req_take && req.kind == gbt_pkg::KIND_CLEAR, used_ff == '0)
   `GBT_ASSERT_IMP(a_queue_order, clock, reset, state_ff == gbt_pkg::S_BFS_POP, rd_ff <= wr_ff && wr_ff <= SW'(NODES))
   `GBT_ASSERT_IMP(a_emit_room, clock, reset, out_load, !out_valid_ff || rsp.ready)

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph traversal block testbench
// drives edge loads, clears and bfs/dfs walks through the request channel and
// checks every response item against a behavioral graph model kept here or a typed-in response
// ----------------------------------------------------------------------------
module testbench;

   localparam int NODES      = 64;
   localparam int ARCS       = 256;
   localparam int RAND_ITEMS = 400;
   localparam int TAIL_WAIT  = 400;

   // one response item as the block emits it
   typedef struct packed {
      logic [gbt_pkg::NODE_W-1:0] node;
      gbt_pkg::status_type        status;
      logic                       last;
   } graph_rsp_type;

   // one directed stimulus row; known rows carry a typed-in single response
   typedef struct {
      gbt_pkg::kind_type          kind;
      logic [gbt_pkg::NODE_W-1:0] first_node;
      logic [gbt_pkg::NODE_W-1:0] second_node;
      logic                       directed;
      bit                         known;
      graph_rsp_type              typed_rsp;
   } graph_cmd_type;

   logic clock;
   logic reset;

   gbt_req_if req ();
   gbt_rsp_if rsp ();

   graph_bfs_dfs_traversal #(.NODES(NODES), .ARCS(ARCS)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // graph model: adjacency lists in an arc pool, the same layout as the block
   // ------------------------------------------------------------------------
   logic [8:0]                 adj_head [NODES];
   logic [8:0]                 adj_tail [NODES];
   logic [gbt_pkg::NODE_W-1:0] pool_target [ARCS];
   logic [8:0]                 pool_next [ARCS];
   int                         pool_used;

   graph_rsp_type due_rsp_q [$];

   int errors;
   int n_stored, n_full, n_clear, n_walks, n_visits, longest_walk;

   // overall time limit
   initial begin
      #10_000_000;
      $display("timeout at %0t, %0d response items still due", $time, due_rsp_q.size());
      $display("TEST FAILED");
      $finish;
   end

   function automatic void wipe_graph();
      for (int i = 0; i < NODES; i++) begin
         adj_head[i] = 9'(ARCS);
         adj_tail[i] = 9'(ARCS);
      end
      pool_used = 0;
   endfunction

   function automatic void link_arc(int from, int to);
      pool_target[pool_used] = gbt_pkg::NODE_W'(to);
      pool_next[pool_used]   = 9'(ARCS);
      if (adj_tail[from] >= ARCS) begin
         adj_head[from] = 9'(pool_used);
      end else begin
         pool_next[adj_tail[from]] = 9'(pool_used);
      end
      adj_tail[from] = 9'(pool_used);
      pool_used++;
   endfunction

   // works out the responses one request causes and updates the graph
   function automatic void walk_graph(input gbt_pkg::kind_type kind, input int a,
                                      input int b, input bit dir,
                                      ref graph_rsp_type outs [$]);
      bit visited [NODES];
      int fifo [NODES];
      int frame_node [NODES];
      int frame_arc [NODES];
      int rd, wr, sp, v, p, t, need;
      outs.delete();
      foreach (visited[i]) visited[i] = 1'b0;
      case (kind)
         gbt_pkg::KIND_EDGE: begin
            need = dir ? 1 : 2;
            if (pool_used + need > ARCS) begin
               outs.insert(outs.size(),
                           graph_rsp_type'{node: '0, status: gbt_pkg::ST_FULL, last: 1'b1});
            end else begin
               link_arc(a, b);
               if (!dir) link_arc(b, a);
               outs.insert(outs.size(),
                           graph_rsp_type'{node: '0, status: gbt_pkg::ST_STORED, last: 1'b1});
            end
         end
         gbt_pkg::KIND_CLEAR: begin
            wipe_graph();
            outs.insert(outs.size(),
                        graph_rsp_type'{node: '0, status: gbt_pkg::ST_CLEARED, last: 1'b1});
         end
         gbt_pkg::KIND_BFS: begin
            rd = 0;
            wr = 0;
            fifo[wr++] = a;
            visited[a] = 1'b1;
            while (rd < wr) begin
               v = fifo[rd++];
               outs.insert(outs.size(), graph_rsp_type'{node: gbt_pkg::NODE_W'(v),
                                                        status: gbt_pkg::ST_VISIT,
                                                        last: 1'b0});
               for (p = adj_head[v]; p < ARCS; p = pool_next[p]) begin
                  t = pool_target[p];
                  if (!visited[t] && wr < NODES) begin
                     visited[t] = 1'b1;
                     fifo[wr++] = t;
                  end
               end
            end
         end
         default: begin
            // depth-first preorder with an explicit frame stack
            sp = 0;
            visited[a] = 1'b1;
            outs.insert(outs.size(), graph_rsp_type'{node: gbt_pkg::NODE_W'(a),
                                                     status: gbt_pkg::ST_VISIT,
                                                     last: 1'b0});
            frame_node[sp] = a;
            frame_arc[sp] = adj_head[a];
            sp++;
            while (sp > 0) begin
               p = frame_arc[sp-1];
               if (p >= ARCS) begin
                  sp--;
               end else begin
                  frame_arc[sp-1] = pool_next[p];
                  t = pool_target[p];
                  if (!visited[t] && sp < NODES) begin
                     visited[t] = 1'b1;
                     outs.insert(outs.size(), graph_rsp_type'{node: gbt_pkg::NODE_W'(t),
                                                              status: gbt_pkg::ST_VISIT,
                                                              last: 1'b0});
                     frame_node[sp] = t;
                     frame_arc[sp] = adj_head[t];
                     sp++;
                  end
               end
            end
         end
      endcase
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // idling control shared by both sides
   // phase 0 none, 1 sender idles, 2 receiver stalls, 3 both
   // ------------------------------------------------------------------------
   int idle_phase;
   int hold_off_cycles;

   // receiver: ready changes on the falling edge only
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            // long stretch with no ready so the block backs up into req
            hold_off_cycles--;
            rsp.ready = 1'b0;
         end else if (idle_phase == 2 || idle_phase == 3) begin
            rsp.ready = ($urandom_range(99) >= (idle_phase == 2 ? 65 : 24));
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   // response checker: sampled at the rising edge
   always @(posedge clock) begin
      graph_rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (due_rsp_q.size() == 0) begin
            $display("%0t: response expected none actual node=%0d status=%0d last=%0b",
                     $time, rsp.node, rsp.status, rsp.last);
            errors++;
         end else begin
            want = due_rsp_q.pop_front();
            if (rsp.node !== want.node) begin
               $display("%0t: node expected %0d actual %0d", $time, want.node, rsp.node);
               errors++;
            end
            if (rsp.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp.status);
               errors++;
            end
            if (rsp.last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp.last);
               errors++;
            end
         end
      end
   end

   // offers one request item and waits for it to be taken; the model is run
   // on the accepting edge, and a known row replaces its output by the typed one
   task automatic send_cmd(input graph_cmd_type cmd);
      graph_rsp_type outs [$];
      if ((idle_phase == 1 || idle_phase == 3) &&
          $urandom_range(99) < (idle_phase == 1 ? 65 : 24)) begin
         req.valid = 1'b0;
         while ($urandom_range(99) < 65) @(negedge clock);
      end
      req.valid       = 1'b1;
      req.kind        = cmd.kind;
      req.first_node  = cmd.first_node;
      req.second_node = cmd.second_node;
      req.directed    = cmd.directed;
      do @(posedge clock); while (!req.ready);
      walk_graph(cmd.kind, cmd.first_node, cmd.second_node, cmd.directed, outs);
      if (cmd.known) begin
         outs.delete();
         outs.insert(0, cmd.typed_rsp);
      end
      foreach (outs[i]) begin
         due_rsp_q.insert(due_rsp_q.size(), outs[i]);
         if (outs[i].status == gbt_pkg::ST_STORED)  n_stored++;
         if (outs[i].status == gbt_pkg::ST_FULL)    n_full++;
         if (outs[i].status == gbt_pkg::ST_CLEARED) n_clear++;
         if (outs[i].status == gbt_pkg::ST_VISIT)   n_visits++;
      end
      if (cmd.kind == gbt_pkg::KIND_BFS || cmd.kind == gbt_pkg::KIND_DFS) begin
         n_walks++;
         if (outs.size() > longest_walk) longest_walk = outs.size();
      end
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   function automatic graph_cmd_type make_cmd(gbt_pkg::kind_type k, int a, int b, bit d);
      graph_cmd_type c;
      c.kind        = k;
      c.first_node  = gbt_pkg::NODE_W'(a);
      c.second_node = gbt_pkg::NODE_W'(b);
      c.directed    = d;
      c.known       = 1'b0;
      c.typed_rsp   = '0;
      return c;
   endfunction

   function automatic graph_cmd_type make_known(gbt_pkg::kind_type k, int a, int b, bit d,
                                                int node, gbt_pkg::status_type st);
      graph_cmd_type c;
      c = make_cmd(k, a, b, d);
      c.known = 1'b1;
      c.typed_rsp = '{node: gbt_pkg::NODE_W'(node), status: st, last: 1'b1};
      return c;
   endfunction

   // random vertex, often from a small cluster so walks get deep
   function automatic int pick_vertex();
      return ($urandom_range(1) != 0) ? $urandom_range(15) : $urandom_range(NODES-1);
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   graph_cmd_type directed_rows [$];

   function automatic void add_row(input graph_cmd_type c);
      directed_rows.insert(directed_rows.size(), c);
   endfunction

   initial begin
      graph_cmd_type cmd;
      int roll;
      errors = 0;
      idle_phase = 0;
      hold_off_cycles = 0;
      n_stored = 0; n_full = 0; n_clear = 0; n_walks = 0; n_visits = 0;
      longest_walk = 0;
      wipe_graph();
      req.valid = 1'b0;
      req.kind = gbt_pkg::KIND_EDGE;
      req.first_node = '0;
      req.second_node = '0;
      req.directed = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty graph walks give just the source
      add_row(make_known(gbt_pkg::KIND_BFS, 0, 0, 0, 0, gbt_pkg::ST_VISIT));
      add_row(make_known(gbt_pkg::KIND_DFS, 63, 0, 1, 63, gbt_pkg::ST_VISIT));
      add_row(make_known(gbt_pkg::KIND_EDGE, 0, 63, 1, 0, gbt_pkg::ST_STORED));
      add_row(make_known(gbt_pkg::KIND_EDGE, 63, 0, 0, 0, gbt_pkg::ST_STORED));
      // self loop stores two arcs, duplicates are stored again
      add_row(make_known(gbt_pkg::KIND_EDGE, 5, 5, 0, 0, gbt_pkg::ST_STORED));
      add_row(make_known(gbt_pkg::KIND_EDGE, 0, 1, 1, 0, gbt_pkg::ST_STORED));
      add_row(make_known(gbt_pkg::KIND_EDGE, 0, 1, 1, 0, gbt_pkg::ST_STORED));
      add_row(make_cmd(gbt_pkg::KIND_EDGE, 1, 42, 0));
      add_row(make_cmd(gbt_pkg::KIND_EDGE, 42, 21, 1));
      add_row(make_cmd(gbt_pkg::KIND_EDGE, 21, 5, 0));
      add_row(make_cmd(gbt_pkg::KIND_BFS, 0, 0, 0));
      add_row(make_cmd(gbt_pkg::KIND_DFS, 0, 0, 0));
      add_row(make_cmd(gbt_pkg::KIND_BFS, 42, 63, 1));
      add_row(make_cmd(gbt_pkg::KIND_DFS, 5, 0, 0));
      add_row(make_cmd(gbt_pkg::KIND_DFS, 63, 0, 0));
      add_row(make_known(gbt_pkg::KIND_CLEAR, 0, 0, 0, 0, gbt_pkg::ST_CLEARED));
      add_row(make_known(gbt_pkg::KIND_BFS, 42, 0, 0, 42, gbt_pkg::ST_VISIT));
      add_row(make_known(gbt_pkg::KIND_EDGE, 21, 42, 0, 0, gbt_pkg::ST_STORED));
      add_row(make_cmd(gbt_pkg::KIND_DFS, 21, 0, 0));
      add_row(make_cmd(gbt_pkg::KIND_BFS, 42, 0, 0));
      foreach (directed_rows[i]) send_cmd(directed_rows[i]);

      // random part: mostly edge loads so the pool fills, walks in between
      for (int n = 0; n < RAND_ITEMS; n++) begin
         idle_phase = (n * 4) / RAND_ITEMS;
         if (n == 60) hold_off_cycles = 600;
         if (n == 300) begin
            // sender pause until every due response has come back
            wait (due_rsp_q.size() == 0);
            repeat (40) @(negedge clock);
         end
         roll = $urandom_range(99);
         if (roll < 58) begin
            cmd = make_cmd(gbt_pkg::KIND_EDGE, pick_vertex(), pick_vertex(),
                           $urandom_range(1));
         end else if (roll < 78) begin
            cmd = make_cmd(gbt_pkg::KIND_BFS, pick_vertex(), $urandom_range(NODES-1),
                           $urandom_range(1));
         end else if (roll < 98) begin
            cmd = make_cmd(gbt_pkg::KIND_DFS, pick_vertex(), $urandom_range(NODES-1),
                           $urandom_range(1));
         end else begin
            cmd = make_cmd(gbt_pkg::KIND_CLEAR, $urandom_range(NODES-1),
                           $urandom_range(NODES-1), $urandom_range(1));
         end
         send_cmd(cmd);
      end

      // drain and give the block time to show any stray response
      idle_phase = 0;
      wait (due_rsp_q.size() == 0);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("covered %0d edges stored, %0d dropped on a full pool, %0d clears",
               n_stored, n_full, n_clear);
      $display("%0d walks with %0d visited vertices, longest walk %0d",
               n_walks, n_visits, longest_walk);
      if (errors == 0 && due_rsp_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
